// ===== rtl/kvl_pkg.sv =====
// Shared types, character constants and result codes for the key/value text lexer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package kvl_pkg;

    localparam int DEF_MAX_DEPTH = 64;

    // Results one document byte can cause, and the widths that follow
    localparam int MAX_RES = 4;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_KEY   = 3'd1,
        KIND_VALUE = 3'd2,
        KIND_OPEN  = 3'd3,
        KIND_CLOSE = 3'd4,
        KIND_DONE  = 3'd5,
        KIND_ERROR = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNTERM     = 3'd1,
        ERR_NO_VALUE   = 3'd2,
        ERR_NO_CLOSE   = 3'd3,
        ERR_BAD_CLOSE  = 3'd4,
        ERR_TOO_DEEP   = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_SLASH   = 3'd2,
        MODE_BARE    = 3'd3,
        MODE_QUOTED  = 3'd4,
        MODE_ESCAPE  = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_doc;
    } kvl_in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [6:0] nest_level;
        err_t       error_code;
        logic       run_last;
    } kvl_result_t;

    // All results of one byte, in order, with their count
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        kvl_result_t [MAX_RES-1:0]       res;
    } kvl_batch_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kvl_lex_core.sv =====
// Lexer state and the per-byte step logic: one byte in, up to MAX_RES results out.
// Depends on kvl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvl_lex_core
    import kvl_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire kvl_in_t    in_item,
    output kvl_batch_t      batch
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    typedef struct packed {
        mode_t                     mode;
        logic                      expv;
        logic [DW-1:0]             depth;
        logic [1:0]                qlen;
        logic [7:0]                first;
        logic                      failed;
        logic [CNT_W-1:0]          n;
        kvl_result_t [MAX_RES-1:0] r;
    } ctx_t;

    mode_t         mode_reg,   mode_next;
    logic          expv_reg,   expv_next;
    logic [DW-1:0] depth_reg,  depth_next;
    logic [1:0]    qlen_reg,   qlen_next;
    logic [7:0]    first_reg,  first_next;
    logic          failed_reg, failed_next;

    function automatic ctx_t emit(input ctx_t c, input kind_t k, input logic [7:0] d,
                                  input err_t e);
        ctx_t          o;
        kvl_result_t   x;
        logic [DW+6:0] wide;
        o    = c;
        wide = {7'd0, c.depth};
        if (c.n < CNT_W'(MAX_RES)) begin
            x.kind       = k;
            x.data_byte  = d;
            x.nest_level = wide[6:0];
            x.error_code = e;
            x.run_last   = 1'b0;
            o.r[c.n[RES_IW-1:0]] = x;
            o.n = c.n + CNT_W'(1);
        end
        return o;
    endfunction

    function automatic ctx_t fail(input ctx_t c, input err_t e);
        ctx_t o;
        o        = emit(c, KIND_ERROR, 8'd0, e);
        o.failed = 1'b1;
        return o;
    endfunction

    // single: the token is the one byte ch, not yet emitted
    function automatic ctx_t finish(input ctx_t c, input logic single, input logic [7:0] ch);
        ctx_t o;
        o = c;
        if (!o.expv) begin
            if (single && ch == CH_RBRACE) begin
                if (o.depth == '0) begin
                    o = fail(o, ERR_BAD_CLOSE);
                end else begin
                    o.depth = o.depth - DW'(1);
                    o = emit(o, KIND_CLOSE, 8'd0, ERR_NONE);
                end
            end else begin
                if (single) o = emit(o, KIND_BYTE, ch, ERR_NONE);
                o = emit(o, KIND_KEY, 8'd0, ERR_NONE);
                o.expv = 1'b1;
            end
        end else begin
            if (single && ch == CH_RBRACE) begin
                o = fail(o, ERR_NO_VALUE);
            end else if (single && ch == CH_LBRACE) begin
                if (o.depth >= DW'(MAX_DEPTH)) begin
                    o = fail(o, ERR_TOO_DEEP);
                end else begin
                    o.depth = o.depth + DW'(1);
                    o = emit(o, KIND_OPEN, 8'd0, ERR_NONE);
                    o.expv = 1'b0;
                end
            end else begin
                if (single) o = emit(o, KIND_BYTE, ch, ERR_NONE);
                o = emit(o, KIND_VALUE, 8'd0, ERR_NONE);
                o.expv = 1'b0;
            end
        end
        return o;
    endfunction

    // First quoted byte is held back until a second one shows the token is not a brace
    function automatic ctx_t add_quoted(input ctx_t c, input logic [7:0] ch);
        ctx_t o;
        o = c;
        if (o.qlen == 2'd0) begin
            o.first = ch;
            o.qlen  = 2'd1;
        end else if (o.qlen == 2'd1) begin
            o = emit(o, KIND_BYTE, o.first, ERR_NONE);
            o = emit(o, KIND_BYTE, ch, ERR_NONE);
            o.qlen = 2'd2;
        end else begin
            o = emit(o, KIND_BYTE, ch, ERR_NONE);
        end
        return o;
    endfunction

    function automatic ctx_t bare_byte(input ctx_t c, input logic [7:0] ch);
        ctx_t o;
        o = c;
        if (ch == CH_LBRACE || ch == CH_RBRACE) begin
            o = finish(o, 1'b0, 8'd0);
            o.mode = MODE_BETWEEN;
            if (!o.failed) o = finish(o, 1'b1, ch);
        end else if (is_space(ch)) begin
            o = finish(o, 1'b0, 8'd0);
            o.mode = MODE_BETWEEN;
        end else begin
            o = emit(o, KIND_BYTE, ch, ERR_NONE);
        end
        return o;
    endfunction

    function automatic ctx_t between(input ctx_t c, input logic [7:0] ch);
        ctx_t o;
        o = c;
        if (is_space(ch)) begin
            o.mode = MODE_BETWEEN;
        end else if (ch == CH_LBRACE || ch == CH_RBRACE) begin
            o = finish(o, 1'b1, ch);
        end else if (ch == CH_QUOTE) begin
            o.mode  = MODE_QUOTED;
            o.qlen  = 2'd0;
            o.first = 8'd0;
        end else if (ch == CH_SLASH) begin
            o.mode = MODE_SLASH;
        end else begin
            o = emit(o, KIND_BYTE, ch, ERR_NONE);
            o.mode = MODE_BARE;
        end
        return o;
    endfunction

    function automatic ctx_t end_document(input ctx_t c);
        ctx_t o;
        o = c;
        if (o.mode == MODE_QUOTED || o.mode == MODE_ESCAPE) begin
            o = fail(o, o.expv ? ERR_NO_VALUE : ERR_UNTERM);
        end else begin
            if (o.mode == MODE_SLASH) begin
                o = emit(o, KIND_BYTE, CH_SLASH, ERR_NONE);
                o = finish(o, 1'b0, 8'd0);
            end else if (o.mode == MODE_BARE) begin
                o = finish(o, 1'b0, 8'd0);
            end
            if (!o.failed) begin
                if (o.expv)              o = fail(o, ERR_NO_VALUE);
                else if (o.depth != '0)  o = fail(o, ERR_NO_CLOSE);
                else                     o = emit(o, KIND_DONE, 8'd0, ERR_NONE);
            end
        end
        return o;
    endfunction

    always_comb begin
        ctx_t             c;
        logic [7:0]       ch;
        logic [CNT_W-1:0] last_n;
        ch       = in_item.text_byte;
        c.mode   = mode_reg;
        c.expv   = expv_reg;
        c.depth  = depth_reg;
        c.qlen   = qlen_reg;
        c.first  = first_reg;
        c.failed = failed_reg;
        c.n      = '0;
        c.r      = '0;
        if (!c.failed) begin
            unique case (c.mode)
                MODE_COMMENT: begin
                    if (ch == CH_LF) c.mode = MODE_BETWEEN;
                end
                MODE_SLASH: begin
                    if (ch == CH_SLASH) begin
                        c.mode = MODE_COMMENT;
                    end else begin
                        c = emit(c, KIND_BYTE, CH_SLASH, ERR_NONE);
                        c.mode = MODE_BARE;
                        c = bare_byte(c, ch);
                    end
                end
                MODE_BARE: c = bare_byte(c, ch);
                MODE_QUOTED: begin
                    if (ch == CH_QUOTE) begin
                        c.mode  = MODE_BETWEEN;
                        c       = finish(c, c.qlen == 2'd1, c.first);
                        c.qlen  = 2'd0;
                        c.first = 8'd0;
                    end else if (ch == CH_BSLASH) begin
                        c.mode = MODE_ESCAPE;
                    end else begin
                        c = add_quoted(c, ch);
                    end
                end
                MODE_ESCAPE: begin
                    c.mode = MODE_QUOTED;
                    c = add_quoted(c, (ch == CH_N) ? CH_LF : ((ch == CH_T) ? CH_TAB : ch));
                end
                MODE_BETWEEN: c = between(c, ch);
                default:      c = between(c, ch);
            endcase
            if (in_item.end_of_doc && !c.failed) c = end_document(c);
        end
        last_n = c.n - CNT_W'(1);
        if (c.n != '0) c.r[last_n[RES_IW-1:0]].run_last = 1'b1;

        batch.count = c.n;
        batch.res   = c.r;

        if (in_item.end_of_doc) begin
            mode_next   = MODE_BETWEEN;
            expv_next   = 1'b0;
            depth_next  = '0;
            qlen_next   = 2'd0;
            first_next  = 8'd0;
            failed_next = 1'b0;
        end else begin
            mode_next   = c.mode;
            expv_next   = c.expv;
            depth_next  = c.depth;
            qlen_next   = c.qlen;
            first_next  = c.first;
            failed_next = c.failed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_BETWEEN;
            expv_reg   <= 1'b0;
            depth_reg  <= '0;
            qlen_reg   <= 2'd0;
            first_reg  <= 8'd0;
            failed_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            expv_reg   <= expv_next;
            depth_reg  <= depth_next;
            qlen_reg   <= qlen_next;
            first_reg  <= first_next;
            failed_reg <= failed_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keyvalue_text_lexer.sv =====
// Top level of the key/value text lexer: input register, lexer core, result buffer.
// Depends on kvl_pkg and kvl_lex_core.
//
// Use:
//   s_valid/s_ready/s_data carry document bytes, one item per byte; end_of_doc
//   marks the final byte. m_valid/m_ready/m_data carry result items (token
//   bytes, key/value ends, open/close, done or error); run_last marks the
//   last result of one input byte. A byte may give no results at all.
// Order: a taken byte waits in the input register until the result buffer is
//   empty or its last item leaves; then it is stepped and its results buffered.
// Throughput: one byte per cycle while m_ready is high and each byte gives at
//   most one result. A byte with more results holds the next step while the buffer
//   drains at most one item per cycle; the next byte waits in the input register.
// Stall: while m_ready is low the current result holds and one further byte is
//   still taken into the input register; s_ready then drops.
// Reset: aresetn, synchronous, active low; clears lexer state, empties both
//   the input register and the result buffer. Lexer state also returns to
//   reset after every end-of-document byte.
`timescale 1ns / 1ps
`default_nettype none

module keyvalue_text_lexer
    import kvl_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire kvl_in_t      s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output kvl_result_t       m_data
);

    // input register
    logic                      in_valid_reg;
    kvl_in_t                   in_data_reg;

    // result buffer: all results of the last stepped byte, read out in order
    kvl_result_t [MAX_RES-1:0] buf_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [RES_IW-1:0]         ptr_reg;

    kvl_batch_t                batch;
    logic                      m_fire;
    logic                      step;

    assign m_valid = (rem_reg != '0);
    assign m_data  = buf_reg[ptr_reg];
    assign m_fire  = m_valid && m_ready;

    // step once the buffer is empty or its last item leaves this cycle
    assign step    = in_valid_reg && ((rem_reg == '0) || ((rem_reg == CNT_W'(1)) && m_fire));
    assign s_ready = !in_valid_reg || step;

    kvl_lex_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .in_item (in_data_reg),
        .batch   (batch)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            ptr_reg <= '0;
        end else if (step) begin
            rem_reg <= batch.count;
            ptr_reg <= '0;
        end else if (m_fire) begin
            rem_reg <= rem_reg - CNT_W'(1);
            ptr_reg <= ptr_reg + RES_IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            buf_reg <= batch.res;
        end
    end

`ifndef ASSERT_OFF
    // buffer never claims more items than one byte can cause
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= CNT_W'(MAX_RES))
        else $error("result buffer count out of range");

    // a step never overwrites results still waiting
    a_step_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> ((rem_reg == '0) || m_fire))
        else $error("lexer step over undelivered results");

    // run_last marks exactly the final buffered result
    a_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.run_last == (rem_reg == CNT_W'(1))))
        else $error("run_last out of step with result buffer");

    // a byte taken while the buffer still holds results must wait in the input register
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> in_valid_reg)
        else $error("input item lost before its step");
`endif

endmodule

`default_nettype wire
